### rtl/xvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xvs_pkg;

    // Particle store geometry
    localparam int MAX_PARTICLES = 4096;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int IDX_W         = 12;

    // Datapath widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIVD_W = 47;
    localparam int DIVS_W = 31;
    localparam int SUM_W  = 48;

    // Item kinds
    typedef enum logic [1:0] {
        ACT_STORE = 2'd0,
        ACT_PAIR  = 2'd1,
        ACT_EMPTY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_VISC   = 2'd0,
        CFG_RADIUS = 2'd1,
        CFG_KNORM  = 2'd2
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE, S_RDJ, S_CAPJ, S_PREP,
        S_MAX, S_MAY, S_MAZ, S_MH, S_QD,
        S_MQ2, S_MQ3, S_MW, S_WAIT, S_MC,
        S_TX, S_TY, S_TZ, S_ACC,
        S_CMAG, S_CH, S_CL, S_CS, S_CF, S_OUT
    } t_state;

    // One particle record; axis 0 is x
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [30:0]      mass;
        logic [31:0]      density;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Clamp an unsigned value to 2^31-1
    function automatic logic [30:0] sat31(input logic [49:0] v);
        return (|v[49:31]) ? {31{1'b1}} : v[30:0];
    endfunction

    // Particle index to store address, modulo store depth
    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] a;
        a = '0;
        for (int b = 0; b < ADDR_W && b < IDX_W; b++) begin
            a[b] = idx[b];
        end
        return a;
    endfunction

endpackage

`default_nettype wire

### rtl/xvs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module xvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/xvs_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module xvs_mul (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [xvs_pkg::MUL_W-1:0]  i_a,
    input  logic [xvs_pkg::MUL_W-1:0]  i_b,
    output logic [xvs_pkg::PROD_W-1:0] o_p
);

    import xvs_pkg::*;

    logic [PROD_W-1:0] r_p;

    // Shared unsigned multiplier, product held while idle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

### rtl/xvs_div.sv
`timescale 1ns / 1ps
`default_nettype none

module xvs_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [xvs_pkg::DIVD_W-1:0] i_dividend,
    input  logic [xvs_pkg::DIVS_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [30:0]               o_quot
);

    import xvs_pkg::*;

    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVS_W:0]   r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W+1:0] rem2;
    logic              ge;

    // One restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        rem2 = {r_rem, r_quo[DIVD_W-1]};
        ge   = (rem2 >= {2'b00, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and quotient share one shift register pass
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (DIVS_W+1)'(rem2 - {2'b00, r_dvs}) : rem2[DIVS_W:0];
            r_quo <= {r_quo[DIVD_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = sat31(50'(r_quo));

endmodule

`default_nettype wire

### rtl/xsph_velocity_smoothing.sv
`timescale 1ns / 1ps
`default_nettype none

// Store item: written into the particle memory at the transfer.
// Pair item: waits on the 47-step serial divider for mass/density.
// After the last pair, and for an empty-list item, the result is computed.
// One item at a time; a finished result waits in the output register.
// Synchronous active-low reset clears control, sums and config registers;
// the particle memory is not cleared.
module xsph_velocity_smoothing (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_action,
    input  logic [xvs_pkg::IDX_W-1:0]  i_index,
    input  logic [xvs_pkg::IDX_W-1:0]  i_other_index,
    input  logic signed [31:0]         i_pos_x,
    input  logic signed [31:0]         i_pos_y,
    input  logic signed [31:0]         i_pos_z,
    input  logic signed [31:0]         i_vel_x,
    input  logic signed [31:0]         i_vel_y,
    input  logic signed [31:0]         i_vel_z,
    input  logic [30:0]                i_mass,
    input  logic signed [31:0]         i_density,
    input  logic                       i_last_of_list,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [xvs_pkg::IDX_W-1:0]  o_particle,
    output logic signed [31:0]         o_new_vel_x,
    output logic signed [31:0]         o_new_vel_y,
    output logic signed [31:0]         o_new_vel_z,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [31:0]                i_cfg_data
);

    import xvs_pkg::*;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    // Saturating add of a signed term into a 48-bit sum
    function automatic logic [SUM_W-1:0] acc_add(input logic [SUM_W-1:0] s,
                                                 input logic [46:0] m,
                                                 input logic neg);
        logic [SUM_W:0] t;
        logic [SUM_W:0] r;
        t = neg ? (~{2'b00, m} + 1'b1) : {2'b00, m};
        r = {s[SUM_W-1], s} + t;
        if (r[SUM_W] != r[SUM_W-1]) begin
            return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return r[SUM_W-1:0];
    endfunction

    // Velocity plus signed correction, saturated to 32 bits
    function automatic logic [31:0] sat_out(input logic [31:0] v,
                                            input logic [33:0] c,
                                            input logic neg);
        logic [34:0] ext;
        logic [34:0] r;
        ext = {{3{v[31]}}, v};
        r   = neg ? (ext - {1'b0, c}) : (ext + {1'b0, c});
        if (r[34:31] == 4'b0000 || r[34:31] == 4'b1111) begin
            return r[31:0];
        end
        return r[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    t_state r_state, n_state;

    // Config registers
    logic [31:0] r_visc;
    logic [30:0] r_radius;
    logic [30:0] r_knorm;

    // Item registers
    logic [IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_jaddr;
    logic              r_last;
    logic              r_empty;

    // Datapath registers
    t_rec        r_rec_i, r_rec_j;
    logic [32:0] r_pmag [3];
    logic [32:0] r_dmag [3];
    logic        r_dneg [3];
    logic        r_far;
    logic [63:0] r_r2;
    logic        r_zero;
    logic [30:0] r_q;
    logic [30:0] r_w;
    logic [30:0] r_coeff;
    logic [SUM_W-1:0] r_sum  [3];
    logic [SUM_W-1:0] r_smag [3];
    logic        r_sneg [3];
    logic [1:0]  r_axis;
    logic [63:0] r_c;
    logic [33:0] r_cc;
    logic [31:0] r_res [3];

    // Output register
    logic             r_out_valid;
    logic [IDX_W-1:0] r_particle;
    logic [31:0]      r_nv [3];

    logic              in_acc;
    logic              out_free;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    t_rec              wr_rec;
    logic [REC_W-1:0]  rd_bits;
    t_rec              rd_rec;

    logic              mul_en;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [49:0]       p_hi;

    logic              div_start;
    logic              div_busy;
    logic [30:0]       div_q;
    logic [30:0]       rho;

    logic [32:0] pm [3];
    logic [32:0] dm [3];
    logic        dn [3];
    logic        far;
    logic [32:0] dp, dd;
    logic [63:0] h2;
    logic [63:0] diff;
    logic [30:0] uv;
    logic [63:0] csum;

    // Input handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visc   <= '0;
            r_radius <= 31'd65536;
            r_knorm  <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_VISC:   r_visc   <= i_cfg_data;
                CFG_RADIUS: r_radius <= i_cfg_data[30:0];
                CFG_KNORM:  r_knorm  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Particle memory: written on store transfers, read for centre then neighbour
    assign ram_we      = in_acc && (t_action'(i_action) == ACT_STORE);
    assign wr_rec.pos  = {i_pos_z, i_pos_y, i_pos_x};
    assign wr_rec.vel  = {i_vel_z, i_vel_y, i_vel_x};
    assign wr_rec.mass = i_mass;
    assign wr_rec.density = i_density;
    assign ram_raddr   = (r_state == S_IDLE) ? to_addr(i_index) : r_jaddr;
    assign rd_rec      = t_rec'(rd_bits);

    xvs_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_PARTICLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (to_addr(i_index)),
        .i_wdata (wr_rec),
        .i_raddr (ram_raddr),
        .o_rdata (rd_bits)
    );

    xvs_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // mass/density with density clamped to at least one LSB
    assign rho = (r_rec_j.density[31] || r_rec_j.density == '0) ? 31'd1
                                                               : r_rec_j.density[30:0];

    xvs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_rec_j.mass, 16'h0000}),
        .i_divisor  (rho),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    assign p_hi = mul_p[65:16];
    assign uv   = (!r_visc[31] && |r_visc[30:0]) ? r_visc[30:0] : '0;

    // Distances and velocity differences per axis
    always_comb begin
        far = 1'b0;
        dp  = '0;
        dd  = '0;
        for (int k = 0; k < 3; k++) begin
            dp    = {r_rec_i.pos[k][31], r_rec_i.pos[k]} - {r_rec_j.pos[k][31], r_rec_j.pos[k]};
            pm[k] = dp[32] ? (~dp + 1'b1) : dp;
            dd    = {r_rec_j.vel[k][31], r_rec_j.vel[k]} - {r_rec_i.vel[k][31], r_rec_i.vel[k]};
            dm[k] = dd[32] ? (~dd + 1'b1) : dd;
            dn[k] = dd[32];
            far   = far || (pm[k] >= {2'b00, r_radius});
        end
    end

    // Kernel and correction helpers
    always_comb begin
        h2   = mul_p[63:0];
        diff = h2 - r_r2;
        csum = r_c + {33'd0, mul_p[46:16]};
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (t_action'(i_action) == ACT_PAIR ||
                               t_action'(i_action) == ACT_EMPTY)) begin
                    n_state = S_RDJ;
                end
            end
            S_RDJ:  n_state = r_empty ? S_CMAG : S_CAPJ;
            S_CAPJ: n_state = S_PREP;
            S_PREP: begin
                div_start = 1'b1;
                n_state   = S_MAX;
            end
            S_MAX:  n_state = S_MAY;
            S_MAY:  n_state = S_MAZ;
            S_MAZ:  n_state = S_MH;
            S_MH:   n_state = S_QD;
            S_QD:   n_state = S_MQ2;
            S_MQ2:  n_state = S_MQ3;
            S_MQ3:  n_state = S_MW;
            S_MW:   n_state = S_WAIT;
            S_WAIT: begin
                if (!div_busy) begin
                    n_state = S_MC;
                end
            end
            S_MC:   n_state = S_TX;
            S_TX:   n_state = S_TY;
            S_TY:   n_state = S_TZ;
            S_TZ:   n_state = S_ACC;
            S_ACC:  n_state = r_last ? S_CMAG : S_IDLE;
            S_CMAG: n_state = S_CH;
            S_CH:   n_state = S_CL;
            S_CL:   n_state = S_CS;
            S_CS:   n_state = S_CF;
            S_CF:   n_state = (r_axis == AXIS_LAST) ? S_OUT : S_CH;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Multiplier operand select
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_MAX: begin mul_a = r_pmag[0]; mul_b = r_pmag[0]; end
            S_MAY: begin mul_a = r_pmag[1]; mul_b = r_pmag[1]; end
            S_MAZ: begin mul_a = r_pmag[2]; mul_b = r_pmag[2]; end
            S_MH:  begin mul_a = {2'b00, r_radius}; mul_b = {2'b00, r_radius}; end
            S_MQ2: begin mul_a = {2'b00, r_q}; mul_b = {2'b00, r_q}; end
            S_MQ3: begin mul_a = {2'b00, sat31(p_hi)}; mul_b = {2'b00, r_q}; end
            S_MW:  begin mul_a = {2'b00, r_knorm}; mul_b = {2'b00, sat31(p_hi)}; end
            S_MC:  begin mul_a = {2'b00, div_q}; mul_b = {2'b00, r_w}; end
            S_TX:  begin mul_a = {2'b00, sat31(p_hi)}; mul_b = r_dmag[0]; end
            S_TY:  begin mul_a = {2'b00, r_coeff}; mul_b = r_dmag[1]; end
            S_TZ:  begin mul_a = {2'b00, r_coeff}; mul_b = r_dmag[2]; end
            S_CH:  begin mul_a = {2'b00, uv}; mul_b = {1'b0, r_smag[r_axis][47:16]}; end
            S_CL:  begin mul_a = {2'b00, uv}; mul_b = {17'd0, r_smag[r_axis][15:0]}; end
            default: mul_en = 1'b0;
        endcase
    end

    // Item capture and datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx   <= i_index;
                r_jaddr <= to_addr(i_other_index);
                r_last  <= i_last_of_list;
                r_empty <= (t_action'(i_action) == ACT_EMPTY);
            end
            S_RDJ:  r_rec_i <= rd_rec;
            S_CAPJ: r_rec_j <= rd_rec;
            S_PREP: begin
                r_far <= far;
                for (int k = 0; k < 3; k++) begin
                    r_pmag[k] <= pm[k];
                    r_dmag[k] <= dm[k];
                    r_dneg[k] <= dn[k];
                end
            end
            S_MAY:  r_r2 <= mul_p[63:0];
            S_MAZ:  r_r2 <= r_r2 + mul_p[63:0];
            S_MH:   r_r2 <= r_r2 + mul_p[63:0];
            S_QD: begin
                r_zero <= r_far || (r_r2 >= h2);
                r_q    <= sat31({2'b00, diff[63:16]});
            end
            S_WAIT: r_w <= r_zero ? '0 : sat31(p_hi);
            S_TX:   r_coeff <= sat31(p_hi);
            S_CMAG: begin
                r_axis <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_sneg[k] <= r_sum[k][SUM_W-1];
                    r_smag[k] <= r_sum[k][SUM_W-1] ? (~r_sum[k] + 1'b1) : r_sum[k];
                end
            end
            S_CL:   r_c <= mul_p[63:0];
            S_CS:   r_cc <= (csum > 64'h2_0000_0000) ? 34'h2_0000_0000 : csum[33:0];
            S_CF: begin
                r_res[r_axis] <= sat_out(r_rec_i.vel[r_axis], r_cc, r_sneg[r_axis]);
                r_axis        <= r_axis + 1'b1;
            end
            default: ;
        endcase
    end

    // Running velocity-difference sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            case (r_state)
                S_RDJ: begin
                    if (r_empty) begin
                        for (int k = 0; k < 3; k++) begin
                            r_sum[k] <= '0;
                        end
                    end
                end
                S_TY:  r_sum[0] <= acc_add(r_sum[0], mul_p[62:16], r_dneg[0]);
                S_TZ:  r_sum[1] <= acc_add(r_sum[1], mul_p[62:16], r_dneg[1]);
                S_ACC: r_sum[2] <= acc_add(r_sum[2], mul_p[62:16], r_dneg[2]);
                S_OUT: begin
                    if (out_free) begin
                        for (int k = 0; k < 3; k++) begin
                            r_sum[k] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_particle <= r_idx;
            for (int k = 0; k < 3; k++) begin
                r_nv[k] <= r_res[k];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_particle  = r_particle;
    assign o_new_vel_x = r_nv[0];
    assign o_new_vel_y = r_nv[1];
    assign o_new_vel_z = r_nv[2];

`ifndef SYNTH
    a_div_free_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |-> !div_busy)
        else $error("divider restarted while busy");

    a_quot_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MC) |-> !div_busy)
        else $error("quotient used before divider finished");

    a_store_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && t_action'(i_action) == ACT_STORE) |=> (r_state == S_IDLE))
        else $error("store transfer did not return to idle");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=>
            (r_sum[0] == '0 && r_sum[1] == '0 && r_sum[2] == '0))
        else $error("sums not cleared after result");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> r_out_valid)
        else $error("result not presented");
`endif

endmodule

`default_nettype wire
